>>> rtl/eftr_pkg.sv
// Shared constants, payload types, command and status types of the triangle rasteriser.
package eftr_pkg;

    localparam int COORD_BITS      = 11;
    localparam int DEPTH_BITS      = 16;
    localparam int RECIP_FRAC_BITS = 32;

    // Edge values reach about three times the square of the coordinate range.
    localparam int EDGE_W   = 2 * COORD_BITS + 3;
    localparam int STEP_W   = COORD_BITS + 1;
    localparam int OPND_W   = COORD_BITS + 2;
    localparam int PROD_W   = 2 * OPND_W;
    localparam int RECIP_W  = RECIP_FRAC_BITS + 1;
    localparam int SUM_W    = DEPTH_BITS + EDGE_W + 1;
    localparam int SUM_LO_W = SUM_W / 2;
    localparam int SUM_HI_W = SUM_W - SUM_LO_W;
    localparam int RACC_W   = SUM_W + RECIP_W;
    localparam int CNT_W    = $clog2(RECIP_FRAC_BITS + 1);

    localparam logic [1:0] EMIT_LOAD_OK    = 2'd0;
    localparam logic [1:0] EMIT_LOAD_REJ   = 2'd1;
    localparam logic [1:0] EMIT_STEP_IDLE  = 2'd2;
    localparam logic [1:0] EMIT_STEP_PIXEL = 2'd3;

    localparam logic [1:0] EVAL_AREA = 2'd3;

    typedef struct packed {
        logic                  op;
        logic [COORD_BITS-1:0] vertex1_x;
        logic [COORD_BITS-1:0] vertex1_y;
        logic [DEPTH_BITS-1:0] vertex1_depth;
        logic [COORD_BITS-1:0] vertex2_x;
        logic [COORD_BITS-1:0] vertex2_y;
        logic [DEPTH_BITS-1:0] vertex2_depth;
        logic [COORD_BITS-1:0] vertex3_x;
        logic [COORD_BITS-1:0] vertex3_y;
        logic [DEPTH_BITS-1:0] vertex3_depth;
        logic [DEPTH_BITS-1:0] stored_depth;
    } in_item_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic                  covered;
        logic [DEPTH_BITS-1:0] pixel_depth;
        logic                  depth_pass;
        logic                  done_res;
        logic                  rejected;
    } out_item_t;

    typedef struct packed {
        logic       capture;
        logic       mac_en;
        logic [1:0] mac_eval;
        logic [1:0] mac_term;
        logic       setup;
        logic       div_step;
        logic       div_first;
        logic       dmac_en;
        logic [1:0] dmac_idx;
        logic       rmul_en;
        logic       rmul_hi;
        logic       emit;
        logic [1:0] emit_kind;
    } cmd_t;

    typedef struct packed {
        logic in_op;
        logic active;
        logic area_zero;
        logic out_free;
    } stat_t;

    function automatic logic [COORD_BITS-1:0] min3(input logic [COORD_BITS-1:0] a,
                                                   input logic [COORD_BITS-1:0] b,
                                                   input logic [COORD_BITS-1:0] c);
        logic [COORD_BITS-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic [COORD_BITS-1:0] max3(input logic [COORD_BITS-1:0] a,
                                                   input logic [COORD_BITS-1:0] b,
                                                   input logic [COORD_BITS-1:0] c);
        logic [COORD_BITS-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

endpackage

>>> rtl/eftr_ctrl.sv
// Sequencing state machine of the triangle rasteriser.
module eftr_ctrl import eftr_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_AREA  = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_EDGE  = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_DMAC  = 3'd5;
    localparam logic [2:0] ST_DMUL  = 3'd6;
    localparam logic [2:0] ST_EMIT  = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       kind_reg, kind_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            kind_reg  <= EMIT_LOAD_OK;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg + CNT_W'(1);
        kind_next     = kind_reg;
        s_ready       = 1'b0;
        cmd           = '0;
        cmd.emit_kind = kind_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cnt_next = '0;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    if (!stat.in_op) begin
                        state_next = ST_AREA;
                    end else if (stat.active) begin
                        state_next = ST_DMAC;
                    end else begin
                        kind_next  = EMIT_STEP_IDLE;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_AREA: begin
                cmd.mac_en   = 1'b1;
                cmd.mac_eval = EVAL_AREA;
                cmd.mac_term = cnt_reg[1:0];
                if (cnt_reg == CNT_W'(3)) begin
                    state_next = ST_CHECK;
                    cnt_next   = '0;
                end
            end
            ST_CHECK: begin
                cnt_next = '0;
                if (stat.area_zero) begin
                    kind_next  = EMIT_LOAD_REJ;
                    state_next = ST_EMIT;
                end else begin
                    cmd.setup  = 1'b1;
                    state_next = ST_EDGE;
                end
            end
            ST_EDGE: begin
                cmd.mac_en   = 1'b1;
                cmd.mac_eval = cnt_reg[3:2];
                cmd.mac_term = cnt_reg[1:0];
                if (cnt_reg == CNT_W'(11)) begin
                    state_next = ST_DIV;
                    cnt_next   = '0;
                end
            end
            ST_DIV: begin
                cmd.div_step  = 1'b1;
                cmd.div_first = (cnt_reg == '0);
                if (cnt_reg == CNT_W'(RECIP_FRAC_BITS)) begin
                    kind_next  = EMIT_LOAD_OK;
                    state_next = ST_EMIT;
                end
            end
            ST_DMAC: begin
                cmd.dmac_en  = 1'b1;
                cmd.dmac_idx = cnt_reg[1:0];
                if (cnt_reg == CNT_W'(2)) begin
                    state_next = ST_DMUL;
                    cnt_next   = '0;
                end
            end
            ST_DMUL: begin
                cmd.rmul_en = 1'b1;
                cmd.rmul_hi = cnt_reg[0];
                if (cnt_reg == CNT_W'(1)) begin
                    kind_next  = EMIT_STEP_PIXEL;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                cnt_next = '0;
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

endmodule

>>> rtl/eftr_datapath.sv
// Edge, reciprocal and depth datapath with the triangle state and output register.
module eftr_datapath import eftr_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  in_item_t  s_data,
    output out_item_t m_data,
    output logic      m_valid,
    input  logic      m_ready,
    input  cmd_t      cmd,
    output stat_t     stat
);

    in_item_t in_reg;

    logic signed [EDGE_W-1:0] mac_acc_reg;
    logic signed [EDGE_W-1:0] area_reg;
    logic signed [EDGE_W-1:0] edge_row_reg [3];
    logic signed [EDGE_W-1:0] edge_cur_reg [3];
    logic signed [STEP_W-1:0] step_x_reg [3];
    logic signed [STEP_W-1:0] step_y_reg [3];
    logic [DEPTH_BITS-1:0]    depth_reg [3];
    logic [RECIP_W-1:0]       recip_reg;
    logic [EDGE_W-2:0]        rem_reg;
    logic [COORD_BITS-1:0]    box_min_x_reg, box_max_x_reg, box_max_y_reg;
    logic [COORD_BITS-1:0]    cur_x_reg, cur_y_reg;
    logic                     active_reg;
    logic [SUM_W-1:0]         dacc_reg;
    logic [RACC_W-1:0]        racc_reg;
    out_item_t                m_data_reg;
    logic                     m_valid_reg;

    logic [COORD_BITS-1:0] vx [3];
    logic [COORD_BITS-1:0] vy [3];
    logic [DEPTH_BITS-1:0] vd [3];
    logic [COORD_BITS-1:0] corner_x, corner_y;

    assign vx[0] = in_reg.vertex1_x;
    assign vx[1] = in_reg.vertex2_x;
    assign vx[2] = in_reg.vertex3_x;
    assign vy[0] = in_reg.vertex1_y;
    assign vy[1] = in_reg.vertex2_y;
    assign vy[2] = in_reg.vertex3_y;
    assign vd[0] = in_reg.vertex1_depth;
    assign vd[1] = in_reg.vertex2_depth;
    assign vd[2] = in_reg.vertex3_depth;
    assign corner_x = min3(vx[0], vx[1], vx[2]);
    assign corner_y = min3(vy[0], vy[1], vy[2]);

    // Edge evaluation: one product per cycle, four terms per edge.
    // The area is edge 1->2 evaluated at the third vertex.
    logic [1:0]               a_idx, b_idx;
    logic [COORD_BITS-1:0]    px, py;
    logic signed [STEP_W-1:0] sx, sy;
    logic signed [OPND_W-1:0] op_a, op_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [EDGE_W-1:0] mac_sum;

    always_comb begin
        a_idx = (cmd.mac_eval == EVAL_AREA) ? 2'd0 : cmd.mac_eval;
        b_idx = (a_idx == 2'd2) ? 2'd0 : a_idx + 2'd1;
        px    = (cmd.mac_eval == EVAL_AREA) ? vx[2] : corner_x;
        py    = (cmd.mac_eval == EVAL_AREA) ? vy[2] : corner_y;
        sx    = $signed({1'b0, vy[a_idx]}) - $signed({1'b0, vy[b_idx]});
        sy    = $signed({1'b0, vx[b_idx]}) - $signed({1'b0, vx[a_idx]});
        unique case (cmd.mac_term)
            2'd0: begin
                op_a = OPND_W'(sx);
                op_b = $signed({2'b00, px});
            end
            2'd1: begin
                op_a = OPND_W'(sy);
                op_b = $signed({2'b00, py});
            end
            2'd2: begin
                op_a = $signed({2'b00, vx[b_idx]});
                op_b = $signed({2'b00, vy[a_idx]});
            end
            2'd3: begin
                op_a = -$signed({2'b00, vx[a_idx]});
                op_b = $signed({2'b00, vy[b_idx]});
            end
        endcase
        prod    = op_a * op_b;
        mac_sum = ((cmd.mac_term == 2'd0) ? EDGE_W'(0) : mac_acc_reg) + prod[EDGE_W-1:0];
    end

    // Restoring division of one in fixed point by the area, one quotient bit a cycle.
    logic [EDGE_W-1:0] div_trial;
    logic              div_bit;

    always_comb begin
        div_trial = {(cmd.div_first ? (EDGE_W-1)'(0) : rem_reg), cmd.div_first};
        div_bit   = (div_trial >= {1'b0, area_reg[EDGE_W-2:0]});
    end

    // Depth: weighted sum of the vertex depths, then scaled by the reciprocal in two halves.
    logic [1:0]                     e_idx;
    logic [DEPTH_BITS+EDGE_W-2:0]   dprod;
    logic [SUM_HI_W-1:0]            rpart;
    logic [SUM_HI_W+RECIP_W-1:0]    rprod;
    logic [RACC_W-RECIP_FRAC_BITS-1:0] dq;
    logic [DEPTH_BITS-1:0]          dsat;
    logic                           covered;

    always_comb begin
        e_idx = (cmd.dmac_idx == 2'd2) ? 2'd0 : cmd.dmac_idx + 2'd1;
        dprod = depth_reg[cmd.dmac_idx] * edge_cur_reg[e_idx][EDGE_W-2:0];
        rpart = cmd.rmul_hi ? dacc_reg[SUM_W-1:SUM_LO_W] : SUM_HI_W'(dacc_reg[SUM_LO_W-1:0]);
        rprod = rpart * recip_reg;
        dq    = racc_reg[RACC_W-1:RECIP_FRAC_BITS];
        dsat  = (|dq[RACC_W-RECIP_FRAC_BITS-1:DEPTH_BITS]) ? '1 : dq[DEPTH_BITS-1:0];
        covered = !edge_cur_reg[0][EDGE_W-1] && !edge_cur_reg[1][EDGE_W-1]
                  && !edge_cur_reg[2][EDGE_W-1];
    end

    // Raster walk.
    logic [COORD_BITS:0] nx, ny;
    logic                row_wrap, box_last;

    always_comb begin
        nx       = {1'b0, cur_x_reg} + (COORD_BITS+1)'(1);
        ny       = {1'b0, cur_y_reg} + (COORD_BITS+1)'(1);
        row_wrap = (nx >= {1'b0, box_max_x_reg});
        box_last = row_wrap && (ny >= {1'b0, box_max_y_reg});
    end

    // Result beat for the kind of item being finished.
    out_item_t emit_item;

    always_comb begin
        emit_item = '0;
        unique case (cmd.emit_kind)
            EMIT_LOAD_OK: begin
            end
            EMIT_LOAD_REJ: begin
                emit_item.rejected = 1'b1;
            end
            EMIT_STEP_IDLE: begin
                emit_item.done_res = 1'b1;
            end
            EMIT_STEP_PIXEL: begin
                emit_item.pixel_x     = cur_x_reg;
                emit_item.pixel_y     = cur_y_reg;
                emit_item.covered     = covered;
                emit_item.pixel_depth = covered ? dsat : '0;
                emit_item.depth_pass  = covered && (in_reg.stored_depth > dsat);
                emit_item.done_res    = box_last;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_reg <= s_data;
        end
        if (cmd.mac_en) begin
            mac_acc_reg <= mac_sum;
            if (cmd.mac_term == 2'd3) begin
                if (cmd.mac_eval == EVAL_AREA) begin
                    area_reg <= mac_sum;
                end else begin
                    edge_row_reg[cmd.mac_eval] <= mac_sum;
                    edge_cur_reg[cmd.mac_eval] <= mac_sum;
                end
            end
        end
        if (cmd.setup) begin
            box_min_x_reg <= corner_x;
            box_max_x_reg <= max3(vx[0], vx[1], vx[2]);
            box_max_y_reg <= max3(vy[0], vy[1], vy[2]);
            cur_x_reg     <= corner_x;
            cur_y_reg     <= corner_y;
            for (int i = 0; i < 3; i++) begin
                step_x_reg[i] <= $signed({1'b0, vy[i]}) - $signed({1'b0, vy[(i + 1) % 3]});
                step_y_reg[i] <= $signed({1'b0, vx[(i + 1) % 3]}) - $signed({1'b0, vx[i]});
                depth_reg[i]  <= vd[i];
            end
        end
        if (cmd.div_step) begin
            rem_reg   <= div_bit ? (EDGE_W-1)'(div_trial - {1'b0, area_reg[EDGE_W-2:0]})
                                 : div_trial[EDGE_W-2:0];
            // A clockwise triangle keeps a zero reciprocal.
            recip_reg <= {recip_reg[RECIP_W-2:0], div_bit & ~area_reg[EDGE_W-1]};
        end
        if (cmd.dmac_en) begin
            dacc_reg <= ((cmd.dmac_idx == 2'd0) ? SUM_W'(0) : dacc_reg) + SUM_W'(dprod);
        end
        if (cmd.rmul_en) begin
            if (cmd.rmul_hi) begin
                racc_reg <= racc_reg + (RACC_W'(rprod) << SUM_LO_W);
            end else begin
                racc_reg <= RACC_W'(rprod);
            end
        end
        if (cmd.emit) begin
            m_data_reg <= emit_item;
            if (cmd.emit_kind == EMIT_STEP_PIXEL) begin
                if (row_wrap) begin
                    cur_x_reg <= box_min_x_reg;
                    cur_y_reg <= ny[COORD_BITS-1:0];
                    for (int i = 0; i < 3; i++) begin
                        edge_row_reg[i] <= edge_row_reg[i] + EDGE_W'(step_y_reg[i]);
                        edge_cur_reg[i] <= edge_row_reg[i] + EDGE_W'(step_y_reg[i]);
                    end
                end else begin
                    cur_x_reg <= nx[COORD_BITS-1:0];
                    for (int i = 0; i < 3; i++) begin
                        edge_cur_reg[i] <= edge_cur_reg[i] + EDGE_W'(step_x_reg[i]);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
                unique case (cmd.emit_kind)
                    EMIT_LOAD_OK:    active_reg <= 1'b1;
                    EMIT_LOAD_REJ:   active_reg <= 1'b0;
                    EMIT_STEP_IDLE:  active_reg <= active_reg;
                    EMIT_STEP_PIXEL: active_reg <= active_reg & ~box_last;
                endcase
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_data         = m_data_reg;
    assign m_valid        = m_valid_reg;
    assign stat.in_op     = s_data.op;
    assign stat.active    = active_reg;
    assign stat.area_zero = (area_reg == '0);
    assign stat.out_free  = !m_valid_reg || m_ready;

endmodule

>>> rtl/edge_function_triangle_raster_core.sv
// Top level of the incremental edge-function triangle rasteriser.
// The input channel (s_valid, s_ready, s_data) takes one beat per item: op = 0 loads a
// triangle, op = 1 visits the next pixel of its bounding box in raster order. Every beat
// gives exactly one result beat on the output channel (m_valid, m_ready, m_data).
// A load evaluates the area and the three corner edge values with one shared multiply-
// accumulate unit, then forms the fixed-point reciprocal of the area in a bit-serial
// divider, one quotient bit a cycle; a zero-area triangle skips the divider.
// A pixel step forms the weighted depth sum and scales it by the reciprocal in two
// halves; a step with nothing loaded goes straight to its result. One item is in
// flight at a time and the next beat is accepted in the cycle after a result is
// registered. Results sit in an output register; a new item is accepted while a
// result still waits, and the block holds its finished result until the register is
// free if the receiver stalls. Synchronous reset leaves no triangle loaded and the
// output channel empty.
module edge_function_triangle_raster_core import eftr_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    cmd_t  cmd;
    stat_t stat;

    eftr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    eftr_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_data  (m_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

endmodule
